/* hdl/slce_pkg.sv */
// Shared types and codes of the sorted list cursor engine.
package slce_pkg;

  localparam int LimitW = 11;
  localparam int KeyW   = 32;
  localparam int IdxW   = 10;
  localparam int PosW   = 11;

  localparam logic [2:0] FUNC_APPEND  = 3'd0;
  localparam logic [2:0] FUNC_REWIND  = 3'd1;
  localparam logic [2:0] FUNC_GETNEXT = 3'd2;
  localparam logic [2:0] FUNC_SEEK    = 3'd3;
  localparam logic [2:0] FUNC_FIND    = 3'd4;
  localparam logic [2:0] FUNC_READ    = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  typedef struct packed {
    logic [5:0]      pad;
    logic [IdxW-1:0] read_index;
    logic [KeyW-1:0] key_value;
  } in_data_t;

  typedef struct packed {
    logic [5:0]      pad;
    logic [1:0]      status;
    logic            ran_out;
    logic            key_found;
    logic [PosW-1:0] left_count;
    logic [PosW-1:0] cursor_pos;
    logic [KeyW-1:0] data_out;
  } out_data_t;

endpackage

/* hdl/slce_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module slce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sorted_list_cursor_engine_unit.sv */
// Top level of the sorted list cursor engine.
//
// Items arrive on the s_axis channel: the operation code in tuser, the key or
// value and the read index in tdata. Every item gives exactly one result item
// on the m_axis channel carrying the entry read, cursor, entries left, the
// find and ran-out flags and a status code. The entry limit register is
// written through cfg_we_i and cfg_wdata_i; the user must write it only while
// the block is idle, which the block does not enforce. One item is in work at
// a time. Every operation passes through the execute and look-up states before
// its result is loaded into the output register; seek and find stay in the
// look-up state for every entry the cursor passes, since the scan reads the
// entry store once per cycle through its single read port. The next item is
// accepted in the cycle after the result is loaded into the output register,
// even while that result is still waiting.
// When the receiver stalls, a finished result waits in the engine until the
// output register frees. Reset empties the list, clears cursor, remaining
// count and entry limit; the entry store itself is not cleared, since only
// written entries are ever read.
module sorted_list_cursor_engine_unit #(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // key_value, read_index
  input  logic [2:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // data_out, cursor_pos, left_count, key_found,
                                     // ran_out, status
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > slce_pkg::LimitW) ? CNT_W : slce_pkg::LimitW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;

  slce_pkg::in_data_t  in_data;
  slce_pkg::out_data_t out_d, out_q;

  logic [1:0]                   state_q, state_d;
  logic [2:0]                   op_q;
  logic [VALUE_BITS-1:0]        key_q;
  logic [slce_pkg::IdxW-1:0]    idx_q;
  logic                         flag_q, flag_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [CNT_W-1:0]             cursor_q, cursor_d;
  logic [CNT_W-1:0]             remain_q, remain_d;
  logic [slce_pkg::LimitW-1:0]  limit_q;
  logic                         m_valid_q, m_valid_d;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  logic in_accept, slot_free, full, out_range, is_seek, scanning, load_out;

  assign in_data   = slce_pkg::in_data_t'(s_axis_tdata);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign slot_free = !m_valid_q || m_axis_tready;

  assign full = (count_q == CNT_W'(CAPACITY)) ||
                ((limit_q != '0) && (CMP_W'(count_q) >= CMP_W'(limit_q)));
  assign out_range = CMP_W'(idx_q) >= CMP_W'(count_q);
  assign is_seek   = (op_q == slce_pkg::FUNC_SEEK) || (op_q == slce_pkg::FUNC_FIND);
  assign scanning  = (state_q == S_LOOK) && is_seek && (remain_q != '0) &&
                     (ram_rdata < key_q);
  assign load_out  = (state_q == S_LOOK) && !scanning && slot_free;

  assign ram_we = (state_q == S_EXEC) && (op_q == slce_pkg::FUNC_APPEND) && !full;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    remain_d  = remain_q;
    flag_d    = flag_q;
    ram_re    = 1'b0;
    ram_raddr = AW'(cursor_q);
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        ram_re  = 1'b1;
        state_d = S_LOOK;
        flag_d  = 1'b0;
        case (op_q)
          slce_pkg::FUNC_APPEND: begin
            flag_d = full;
            if (!full) begin
              count_d = count_q + 1'b1;
            end
          end
          slce_pkg::FUNC_REWIND: begin
            cursor_d  = '0;
            remain_d  = count_q;
            ram_raddr = '0;
          end
          slce_pkg::FUNC_GETNEXT: begin
            if (remain_q == '0) begin
              flag_d = 1'b1;
            end else begin
              cursor_d = cursor_q + 1'b1;
              remain_d = remain_q - 1'b1;
            end
          end
          slce_pkg::FUNC_READ: begin
            flag_d    = out_range;
            ram_raddr = AW'(idx_q);
          end
          default: begin
          end
        endcase
      end
      S_LOOK: begin
        if (scanning) begin
          cursor_d  = cursor_q + 1'b1;
          remain_d  = remain_q - 1'b1;
          ram_re    = 1'b1;
          ram_raddr = AW'(cursor_q + 1'b1);
        end else if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d            = '0;
    out_d.cursor_pos = slce_pkg::PosW'(cursor_q);
    out_d.left_count = slce_pkg::PosW'(remain_q);
    out_d.ran_out    = is_seek && (remain_q == '0);
    out_d.key_found  = (op_q == slce_pkg::FUNC_FIND) && (remain_q != '0) &&
                       (ram_rdata == key_q);
    out_d.status     = slce_pkg::STATUS_OK;
    if (remain_q != '0) begin
      out_d.data_out = slce_pkg::KeyW'(ram_rdata);
    end
    case (op_q)
      slce_pkg::FUNC_APPEND: begin
        if (flag_q) begin
          out_d.status = slce_pkg::STATUS_FULL;
        end
      end
      slce_pkg::FUNC_GETNEXT: begin
        out_d.data_out = flag_q ? '0 : slce_pkg::KeyW'(ram_rdata);
        if (flag_q) begin
          out_d.status = slce_pkg::STATUS_EMPTY;
        end
      end
      slce_pkg::FUNC_READ: begin
        out_d.data_out = flag_q ? '0 : slce_pkg::KeyW'(ram_rdata);
        if (flag_q) begin
          out_d.status = slce_pkg::STATUS_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cursor_q  <= '0;
      remain_q  <= '0;
      limit_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      cursor_q  <= cursor_d;
      remain_q  <= remain_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q <= flag_d;
    if (in_accept) begin
      op_q  <= s_axis_tuser;
      key_q <= VALUE_BITS'(in_data.key_value);
      idx_q <= in_data.read_index;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  slce_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(count_q)),
    .wdata_i (key_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

/* hdl/slce_checker.sv */
// Port-level checks of the sorted list cursor engine, bound to its top level.
module slce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic [63:0] m_axis_tdata
);

  slce_pkg::out_data_t res;
  logic                in_accept;

  assign res       = slce_pkg::out_data_t'(m_axis_tdata);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready)
    else $error("Input taken again while an item is in work.");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !$rose(m_axis_tvalid))
    else $error("Result appeared one cycle after its item was taken.");

  a_ran_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.ran_out) |-> (res.left_count == '0 && !res.key_found))
    else $error("Ran-out result still shows entries left or a match.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res.status == slce_pkg::STATUS_EMPTY ||
                       res.status == slce_pkg::STATUS_RANGE)) |-> (res.data_out == '0))
    else $error("Failed read returned nonzero data.");

  a_empty_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.status == slce_pkg::STATUS_EMPTY) |-> (res.left_count == '0))
    else $error("Empty cursor reported with entries left.");

endmodule

bind sorted_list_cursor_engine_unit slce_checker u_slce_checker (.*);
